/* rtl/bps_pkg.sv */
// bps_pkg: shared widths, defaults and register indexes for byte_pattern_search
// no dependencies
`default_nettype none

package bps_pkg;

  localparam int DATA_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int OFFSET_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int              MAX_PATTERN_LENGTH_DEF = 8;
  localparam longint unsigned MAX_SOURCE_LENGTH_DEF  = 64'd65536;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PATTERN_BYTES  = 2'd0;
  localparam cfg_index_t REG_PATTERN_LENGTH = 2'd1;
  localparam cfg_index_t REG_FIND_LAST      = 2'd2;

endpackage

`default_nettype wire

/* rtl/byte_pattern_search.sv */
// byte_pattern_search: one byte per cycle, the newest pattern_length bytes (clamped to
// 1..MAX_PATTERN_LENGTH) of a sliding window are compared in parallel with the pattern
// on every transfer; the result is registered on the transfer of the byte marked last.
// throughput: one byte per cycle; only a last byte waits while an older result is unread.
// reset: synchronous; pattern 0, length 1, first-match mode, stream and out_valid cleared
// depends on bps_pkg
`default_nettype none

module byte_pattern_search #(
  parameter int              MAX_PATTERN_LENGTH = bps_pkg::MAX_PATTERN_LENGTH_DEF,
  parameter longint unsigned MAX_SOURCE_LENGTH  = bps_pkg::MAX_SOURCE_LENGTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire bps_pkg::cfg_index_t         cfg_index,
  input  wire logic [bps_pkg::PAT_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bps_pkg::DATA_W-1:0]  data_byte,
  input  wire logic                        last_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             match_found,
  output logic [bps_pkg::OFFSET_W-1:0]     match_offset
);
  import bps_pkg::*;

  localparam int P     = MAX_PATTERN_LENGTH;
  localparam int WIN_W = P * DATA_W;
  localparam int CW    = $clog2(MAX_SOURCE_LENGTH + 64'd1);

  logic [PAT_W-1:0]    pattern_bytes;
  logic [LEN_W-1:0]    pattern_length;
  logic                find_last;

  logic [WIN_W-1:0]    window_bytes;
  logic [CW-1:0]       bytes_seen;
  logic                have_match;
  logic [OFFSET_W-1:0] kept_offset;

  logic [WIN_W-1:0]    window_next;
  logic [CW-1:0]       bytes_seen_next;
  logic                have_match_next;
  logic [OFFSET_W-1:0] kept_offset_next;
  logic                out_valid_next;

  logic                in_xfer;
  logic                in_room;
  logic [LEN_W-1:0]    len;
  logic [P:1]          eq_len;
  logic                hit;
  logic [CW-1:0]       start;

  assign cfg_ready = 1'b1;
  assign in_room   = !out_valid || out_ready;
  assign in_ready  = in_room || !last_byte;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= LEN_W'(1);
      find_last      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_FIND_LAST:      find_last      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(P)) begin
      len = LEN_W'(P);
    end else begin
      len = pattern_length;
    end
  end

  assign window_next = {data_byte, window_bytes[WIN_W-1:DATA_W]};

  // compare for each possible length: newest L lanes against first L pattern bytes
  always_comb begin
    for (int l = 1; l <= P; l++) begin
      eq_len[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (window_next[(P-l+i)*DATA_W +: DATA_W] != pattern_bytes[i*DATA_W +: DATA_W]) begin
          eq_len[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= P; l++) begin
      if (len == LEN_W'(l)) begin
        hit = eq_len[l];
      end
    end
  end

  assign start = bytes_seen_next - CW'(len);

  always_comb begin
    bytes_seen_next  = bytes_seen + CW'(1);
    have_match_next  = have_match;
    kept_offset_next = kept_offset;
    if (in_xfer && (bytes_seen < CW'(MAX_SOURCE_LENGTH))) begin
      if ((bytes_seen_next >= CW'(len)) && hit && (find_last || !have_match)) begin
        have_match_next  = 1'b1;
        kept_offset_next = start[OFFSET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes <= '0;
      bytes_seen   <= '0;
      have_match   <= 1'b0;
      kept_offset  <= '0;
    end else if (in_xfer) begin
      if (last_byte) begin
        window_bytes <= '0;
        bytes_seen   <= '0;
        have_match   <= 1'b0;
        kept_offset  <= '0;
      end else if (bytes_seen < CW'(MAX_SOURCE_LENGTH)) begin
        window_bytes <= window_next;
        bytes_seen   <= bytes_seen_next;
        have_match   <= have_match_next;
        kept_offset  <= kept_offset_next;
      end
    end
  end

  always_comb begin
    if (in_xfer && last_byte) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      match_found  <= have_match_next;
      match_offset <= have_match_next ? kept_offset_next : '0;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last_byte) |=> (bytes_seen == '0 && !have_match && out_valid))
    else $error("stream state not cleared or result missing after last transfer");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !match_found) |-> (match_offset == '0))
    else $error("nonzero offset without a match");

  a_kept_zero: assert property (@(posedge clk) disable iff (rst)
    !have_match |-> (kept_offset == '0))
    else $error("kept offset set without a match");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= CW'(MAX_SOURCE_LENGTH))
    else $error("byte count beyond source limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(in_xfer && last_byte))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
